/* hdl/ttrq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ttrq_pkg;

    // Ring geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    // Field widths
    localparam int TIME_BITS = 48;
    localparam int VOICE_W   = 3;
    localparam int VEL_W     = 7;
    localparam int CAUSE_W   = 2;
    localparam int NW_W      = 10;

    localparam logic [NW_W-1:0] NW_RESET = NW_W'(48);

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_IDX_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Input command codes
    localparam logic CMD_SCHED = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Fire cause codes
    localparam logic [CAUSE_W-1:0] CAUSE_DUE  = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_NEAR = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_FULL = 2'd2;

    // Work classes decided by the front
    typedef enum logic [1:0] {
        KIND_NEAR,
        KIND_SCHED,
        KIND_TICK
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [VOICE_W-1:0]   voice;
        logic [VEL_W-1:0]     velocity;
        logic [TIME_BITS-1:0] fire_time;
        logic [TIME_BITS-1:0] now;
    } cmd_t;

    // Ring index increment with wrap for any depth
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(QUEUE_DEPTH - 1))
            res = '0;
        else
            res = idx + IDX_W'(1);
        return res;
    endfunction

endpackage

`default_nettype wire

/* hdl/timed_trigger_ring_queue_unit.sv */
// With the back end idle, an immediate fire (near or ring full) passes through the command queue
// and is then registered in the output register.
// The back end stores a schedule from its idle state; a tick scans the ring from tail to head,
// one slot per cycle unless a due fire must wait for a stalled output.
// A two-entry command queue lets new items be taken while the back end scans or the output stalls.
// Reset (rst_n, async low): ring empty, head and tail zero, near window 48, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none

module timed_trigger_ring_queue_unit
    import ttrq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [NW_W-1:0]      cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 cmd,
    input  wire logic [VOICE_W-1:0]   voice,
    input  wire logic [VEL_W-1:0]     velocity,
    input  wire logic [TIME_BITS-1:0] fire_time,
    input  wire logic [TIME_BITS-1:0] now,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [VOICE_W-1:0]        fire_voice,
    output logic [VEL_W-1:0]          fire_velocity,
    output logic [CAUSE_W-1:0]        fire_cause,
    output logic                      last_of_run
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t q_in_item;
    cmd_t q_out_item;

    // Front: near-window test and classification
    ttrq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .voice     (voice),
        .velocity  (velocity),
        .fire_time (fire_time),
        .now       (now),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in_item)
    );

    // Command queue
    ttrq_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .item      (q_out_item)
    );

    // Back: ring storage, scan and fire output
    ttrq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_out_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fire_voice    (fire_voice),
        .fire_velocity (fire_velocity),
        .fire_cause    (fire_cause),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire

/* hdl/ttrq_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ttrq_front
    import ttrq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [NW_W-1:0]      cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 cmd,
    input  wire logic [VOICE_W-1:0]   voice,
    input  wire logic [VEL_W-1:0]     velocity,
    input  wire logic [TIME_BITS-1:0] fire_time,
    input  wire logic [TIME_BITS-1:0] now,
    input  wire logic                 q_full,
    output logic                      q_push,
    output cmd_t                      q_item
);

    logic [NW_W-1:0]      near_window_reg;
    logic [TIME_BITS-1:0] ahead;
    logic                 is_near;

    // Near window register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            near_window_reg <= NW_RESET;
        else if (cfg_we)
            near_window_reg <= cfg_wdata;
    end

    // Due test: already past, or within the near window
    always_comb
    begin
        ahead   = fire_time - now;
        is_near = (fire_time <= now) || (ahead <= TIME_BITS'(near_window_reg));
    end

    // Classify and hand off to the command queue
    always_comb
    begin
        q_item.voice     = voice;
        q_item.velocity  = velocity;
        q_item.fire_time = fire_time;
        q_item.now       = now;
        if (cmd == CMD_TICK)
            q_item.kind = KIND_TICK;
        else if (is_near)
            q_item.kind = KIND_NEAR;
        else
            q_item.kind = KIND_SCHED;
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

/* hdl/ttrq_cmdq.sv */
`timescale 1ns / 1ps
`default_nettype none

module ttrq_cmdq
    import ttrq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_item,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output cmd_t      item
);

    cmd_t                  mem_reg [CMDQ_DEPTH];
    logic [CMDQ_IDX_W-1:0] wr_ptr_reg;
    logic [CMDQ_IDX_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign valid   = (count_reg != '0);
    assign item    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                if (wr_ptr_reg == CMDQ_IDX_W'(CMDQ_DEPTH - 1))
                    wr_ptr_reg <= '0;
                else
                    wr_ptr_reg <= wr_ptr_reg + CMDQ_IDX_W'(1);
            end
            if (do_pop)
            begin
                if (rd_ptr_reg == CMDQ_IDX_W'(CMDQ_DEPTH - 1))
                    rd_ptr_reg <= '0;
                else
                    rd_ptr_reg <= rd_ptr_reg + CMDQ_IDX_W'(1);
            end
            if (do_push && !do_pop)
                count_reg <= count_reg + CMDQ_CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CMDQ_CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

/* hdl/ttrq_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ttrq_back
    import ttrq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire cmd_t                q_item,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [VOICE_W-1:0]       fire_voice,
    output logic [VEL_W-1:0]         fire_velocity,
    output logic [CAUSE_W-1:0]       fire_cause,
    output logic                     last_of_run
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Ring storage
    logic [VOICE_W-1:0]   slot_voice_reg    [QUEUE_DEPTH];
    logic [VEL_W-1:0]     slot_velocity_reg [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] slot_time_reg     [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] slot_active_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [TIME_BITS-1:0] now_reg, now_next;

    // One fire held back until we know whether it is the last of the tick
    logic               pend_valid_reg, pend_valid_next;
    logic [VOICE_W-1:0] pend_voice_reg, pend_voice_next;
    logic [VEL_W-1:0]   pend_vel_reg, pend_vel_next;

    // Output register
    logic               out_valid_reg;
    logic [VOICE_W-1:0] out_voice_reg;
    logic [VEL_W-1:0]   out_vel_reg;
    logic [CAUSE_W-1:0] out_cause_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               push;
    logic [VOICE_W-1:0] push_voice;
    logic [VEL_W-1:0]   push_vel;
    logic [CAUSE_W-1:0] push_cause;
    logic               push_last;
    logic               slot_wr;
    logic               act_clr;
    logic               cur_active;
    logic               hit;

    assign out_free   = !out_valid_reg || !out_stall;
    assign cur_active = slot_active_reg[cur_reg];
    assign hit        = cur_active && (now_reg >= slot_time_reg[cur_reg]);

    // Sequencer: one command, or one ring slot per cycle during a tick, unless held by a stalled output
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_voice_next = pend_voice_reg;
        pend_vel_next   = pend_vel_reg;
        q_pop           = 1'b0;
        push            = 1'b0;
        push_voice      = q_item.voice;
        push_vel        = q_item.velocity;
        push_cause      = CAUSE_NEAR;
        push_last       = 1'b1;
        slot_wr         = 1'b0;
        act_clr         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.kind)
                        KIND_NEAR:
                        begin
                            if (out_free)
                            begin
                                push  = 1'b1;
                                q_pop = 1'b1;
                            end
                        end
                        KIND_SCHED:
                        begin
                            if (next_idx(head_reg) == tail_reg)
                            begin
                                // ring full: fire at once
                                if (out_free)
                                begin
                                    push       = 1'b1;
                                    push_cause = CAUSE_FULL;
                                    q_pop      = 1'b1;
                                end
                            end
                            else
                            begin
                                slot_wr   = 1'b1;
                                head_next = next_idx(head_reg);
                                q_pop     = 1'b1;
                            end
                        end
                        KIND_TICK:
                        begin
                            q_pop      = 1'b1;
                            now_next   = q_item.now;
                            cur_next   = tail_reg;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cur_reg == head_reg)
                begin
                    // end of scan: release the held fire as the last one
                    if (pend_valid_reg)
                    begin
                        if (out_free)
                        begin
                            push            = 1'b1;
                            push_voice      = pend_voice_reg;
                            push_vel        = pend_vel_reg;
                            push_cause      = CAUSE_DUE;
                            pend_valid_next = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!(hit && pend_valid_reg && !out_free))
                begin
                    if (hit)
                    begin
                        act_clr = 1'b1;
                        if (pend_valid_reg)
                        begin
                            push       = 1'b1;
                            push_voice = pend_voice_reg;
                            push_vel   = pend_vel_reg;
                            push_cause = CAUSE_DUE;
                            push_last  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_voice_next = slot_voice_reg[cur_reg];
                        pend_vel_next   = slot_velocity_reg[cur_reg];
                    end
                    // tail follows the scan while it crosses fired or empty slots
                    if ((cur_reg == tail_reg) && (hit || !cur_active))
                        tail_next = next_idx(cur_reg);
                    cur_next = next_idx(cur_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            cur_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            slot_active_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cur_reg        <= cur_next;
            pend_valid_reg <= pend_valid_next;
            if (slot_wr)
                slot_active_reg[head_reg] <= 1'b1;
            if (act_clr)
                slot_active_reg[cur_reg] <= 1'b0;
            if (push)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        pend_voice_reg <= pend_voice_next;
        pend_vel_reg  <= pend_vel_next;
        if (slot_wr)
        begin
            slot_voice_reg[head_reg]    <= q_item.voice;
            slot_velocity_reg[head_reg] <= q_item.velocity;
            slot_time_reg[head_reg]     <= q_item.fire_time;
        end
        if (push)
        begin
            out_voice_reg <= push_voice;
            out_vel_reg   <= push_vel;
            out_cause_reg <= push_cause;
            out_last_reg  <= push_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fire_voice    = out_voice_reg;
    assign fire_velocity = out_vel_reg;
    assign fire_cause    = out_cause_reg;
    assign last_of_run   = out_last_reg;

endmodule

`default_nettype wire

/* tb/timed_trigger_ring_queue_unit_tb.sv */
`timescale 1ns / 1ps

module timed_trigger_ring_queue_unit_tb;
    import ttrq_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ITEMS  = 100;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [VEL_W-1:0]   velocity;
        logic [CAUSE_W-1:0] cause;
        logic               last;
    } fire_t;

    // Ring predictor plus the queue of fires it still waits for
    class trigger_ring_model;
        logic [VOICE_W-1:0]   trig_voice [QUEUE_DEPTH];
        logic [VEL_W-1:0]     trig_vel   [QUEUE_DEPTH];
        logic [TIME_BITS-1:0] trig_time  [QUEUE_DEPTH];
        bit                   trig_armed [QUEUE_DEPTH];
        logic [IDX_W-1:0]     head;
        logic [IDX_W-1:0]     tail;
        logic [NW_W-1:0]      window;
        fire_t                pending_fires[$];
        int                   errors;
        int                   items;
        int                   by_cause[4];

        function new();
            head   = '0;
            tail   = '0;
            window = NW_RESET;
        endfunction

        function logic [IDX_W-1:0] step_idx(logic [IDX_W-1:0] i);
            return IDX_W'((int'(i) + 1) % QUEUE_DEPTH);
        endfunction

        function void push_fire(logic [VOICE_W-1:0] v, logic [VEL_W-1:0] vel,
                                logic [CAUSE_W-1:0] cause);
            fire_t f;
            f.voice    = v;
            f.velocity = vel;
            f.cause    = cause;
            f.last     = 1'b0;
            pending_fires.push_back(f);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        // One accepted transfer: work out the fires it causes
        function void take_item(logic c, logic [VOICE_W-1:0] v, logic [VEL_W-1:0] vel,
                                logic [TIME_BITS-1:0] ft, logic [TIME_BITS-1:0] tnow);
            logic [IDX_W-1:0] cur;
            int               seen;
            int               n;
            n = 0;
            items++;
            if (c == CMD_SCHED) begin
                if (ft <= tnow || (ft - tnow) <= TIME_BITS'(window)) begin
                    push_fire(v, vel, CAUSE_NEAR);
                    n = 1;
                end else if (step_idx(head) == tail) begin
                    push_fire(v, vel, CAUSE_FULL);
                    n = 1;
                end else begin
                    trig_voice[head] = v;
                    trig_vel[head]   = vel;
                    trig_time[head]  = ft;
                    trig_armed[head] = 1'b1;
                    head = step_idx(head);
                end
            end else begin
                // scan tail to head, retire due slots in ring order
                cur  = tail;
                seen = 0;
                while (cur != head && seen < QUEUE_DEPTH) begin
                    if (trig_armed[cur] && tnow >= trig_time[cur]) begin
                        push_fire(trig_voice[cur], trig_vel[cur], CAUSE_DUE);
                        n++;
                        trig_armed[cur] = 1'b0;
                        if (cur == tail) begin
                            while (tail != head && !trig_armed[tail])
                                tail = step_idx(tail);
                        end
                    end
                    cur = step_idx(cur);
                    seen++;
                end
            end
            if (n > 0)
                pending_fires[pending_fires.size() - 1].last = 1'b1;
        endfunction

        // One fire transfer from the block against the oldest expectation
        function void match_fire(fire_t got);
            fire_t want;
            if (pending_fires.size() == 0) begin
                flag($sformatf("unexpected fire: voice %0d vel %0d cause %0d last %0d",
                               got.voice, got.velocity, got.cause, got.last));
                return;
            end
            want = pending_fires.pop_front();
            by_cause[want.cause]++;
            if (got.voice !== want.voice || got.velocity !== want.velocity ||
                got.cause !== want.cause || got.last !== want.last)
                flag($sformatf({"fire mismatch: expected voice %0d vel %0d cause %0d last %0d,",
                                " got voice %0d vel %0d cause %0d last %0d"},
                               want.voice, want.velocity, want.cause, want.last,
                               got.voice, got.velocity, got.cause, got.last));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [NW_W-1:0]      cfg_wdata;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic [VOICE_W-1:0]   voice;
    logic [VEL_W-1:0]     velocity;
    logic [TIME_BITS-1:0] fire_time;
    logic [TIME_BITS-1:0] now;
    logic                 out_valid;
    logic                 out_stall;
    logic [VOICE_W-1:0]   fire_voice;
    logic [VEL_W-1:0]     fire_velocity;
    logic [CAUSE_W-1:0]   fire_cause;
    logic                 last_of_run;

    trigger_ring_model ring = new();
    int                cycles = 0;
    int                settings = 0;

    timed_trigger_ring_queue_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .voice         (voice),
        .velocity      (velocity),
        .fire_time     (fire_time),
        .now           (now),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fire_voice    (fire_voice),
        .fire_velocity (fire_velocity),
        .fire_cause    (fire_cause),
        .last_of_run   (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Fire side: runs of open cycles broken by stalls, mostly short
    initial
    begin
        int pick;
        int len;
        out_stall = 1'b0;
        forever begin
            repeat ($urandom_range(1, 30)) @(negedge clk);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 2);
            else if (pick < 95)
                len = $urandom_range(3, 8);
            else
                len = $urandom_range(20, 40);
            out_stall <= 1'b1;
            repeat (len) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    // Check every fire transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ring.match_fire({fire_voice, fire_velocity, fire_cause, last_of_run});
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[TIME_BITS-1:0];
    endfunction

    // Present one item, hold it until the transfer, then idle a random gap
    task automatic send_item(input logic c, input logic [VOICE_W-1:0] v,
                             input logic [VEL_W-1:0] vel,
                             input logic [TIME_BITS-1:0] ft,
                             input logic [TIME_BITS-1:0] tnow);
        int pick;
        int gap;
        @(negedge clk);
        in_valid  <= 1'b1;
        cmd       <= c;
        voice     <= v;
        velocity  <= vel;
        fire_time <= ft;
        now       <= tnow;
        do
            @(posedge clk);
        while (in_stall);
        ring.take_item(c, v, vel, ft, tnow);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else if (pick < 98)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 40);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Hold off until every fire is back and any silent scan is over
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (ring.pending_fires.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [NW_W-1:0] nw);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= nw;
        @(negedge clk);
        cfg_we    <= 1'b0;
        ring.window = nw;
        settings++;
    endtask

    // Random phase: mostly a running clock with schedules around it, some noise
    task automatic run_phase(input int count, input logic [NW_W-1:0] nw,
                             input logic [TIME_BITS-1:0] base);
        logic [TIME_BITS-1:0] cur;
        logic [TIME_BITS-1:0] ft;
        logic [TIME_BITS-1:0] tnow;
        int                   roll;
        int                   sub;
        write_window(nw);
        cur = base;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                send_item(1'($urandom_range(0, 1)), VOICE_W'($urandom), VEL_W'($urandom),
                          rand_time(), rand_time());
            end else if (roll < 55) begin
                sub = $urandom_range(0, 9);
                if (sub < 2)
                    ft = cur - $urandom_range(0, 50);
                else if (sub < 4)
                    ft = cur + $urandom_range(0, int'(nw));
                else
                    ft = cur + nw + 1 + $urandom_range(0, 400);
                send_item(CMD_SCHED, VOICE_W'($urandom), VEL_W'($urandom), ft, cur);
            end else begin
                cur  = cur + $urandom_range(0, 120);
                tnow = ($urandom_range(0, 19) == 0) ? cur - $urandom_range(1, 200) : cur;
                send_item(CMD_TICK, VOICE_W'($urandom), VEL_W'($urandom), rand_time(), tnow);
            end
        end
        // late tick empties the ring before the next setting
        send_item(CMD_TICK, VOICE_W'($urandom), VEL_W'($urandom), rand_time(), '1);
        drain();
    endtask

    initial
    begin
        int directed;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        cmd       = CMD_SCHED;
        voice     = '0;
        velocity  = '0;
        fire_time = '0;
        now       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: window edges, time extremes, out-of-order retire, ring full
        write_window(NW_RESET);
        send_item(CMD_SCHED, 3'd0, 7'd0, '0, '1);
        send_item(CMD_SCHED, 3'd7, 7'd127, 48'd1048, 48'd1000);
        send_item(CMD_SCHED, 3'd1, 7'd5, '1, '0);
        send_item(CMD_SCHED, 3'd2, 7'd64, 48'd1049, 48'd1000);
        send_item(CMD_TICK, VOICE_W'($urandom), VEL_W'($urandom), rand_time(), 48'd1000);
        send_item(CMD_TICK, VOICE_W'($urandom), VEL_W'($urandom), rand_time(), 48'd1049);
        for (int k = 0; k < 14; k++)
            send_item(CMD_SCHED, VOICE_W'(k), VEL_W'($urandom), 48'd2000 + k, 48'd1000);
        send_item(CMD_TICK, VOICE_W'($urandom), VEL_W'($urandom), rand_time(), 48'd2005);
        send_item(CMD_TICK, VOICE_W'($urandom), VEL_W'($urandom), rand_time(), '1);
        drain();
        directed = ring.items;

        run_phase(RANDOM_ITEMS, '0, '0);
        run_phase(RANDOM_ITEMS, '1, rand_time());
        run_phase(RANDOM_ITEMS, NW_W'($urandom), 48'hFFFF_FFFF_F000);
        run_phase(RANDOM_ITEMS, NW_W'(1), rand_time());
        run_phase(RANDOM_ITEMS, NW_W'($urandom), rand_time());

        if (ring.pending_fires.size() != 0)
            ring.flag($sformatf("%0d expected fires never arrived",
                                ring.pending_fires.size()));

        $display("Run covered %0d items (%0d directed) over %0d near-window settings.",
                 ring.items, directed, settings);
        $display("Fires checked: %0d due from ring, %0d near, %0d ring full; %0d mismatches.",
                 ring.by_cause[CAUSE_DUE], ring.by_cause[CAUSE_NEAR],
                 ring.by_cause[CAUSE_FULL], ring.errors);
        if (ring.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
